[hdl/plti_pkg.sv]
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants for the piecewise linear interpolation unit.
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CntW      = 7;
  localparam int unsigned DataW     = 32;
  // Divider: 48-bit dividend, 32-bit divisor, one quotient bit per cell pass.
  localparam int unsigned QuotW     = 48;
  localparam int unsigned DivCells  = 4;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [IdxW-1:0]    point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } plti_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic               inside_span;
    logic [IdxW-1:0]    segment;
  } plti_out_t;

  // Partial remainder handed from one divider cell to the next.
  typedef struct packed {
    logic [DataW:0]   rem;
    logic [QuotW-1:0] num;
    logic [QuotW-1:0] quo;
  } plti_div_t;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StWrite  = 7'b0000010,
    StSearch = 7'b0000100,
    StFetch  = 7'b0001000,
    StDivS   = 7'b0010000,
    StDivT   = 7'b0100000,
    StDone   = 7'b1000000
  } plti_state_e;

endpackage

[hdl/piecewise_linear_table_interp_unit.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_unit
// Breakpoint table with binary search and fixed-point linear interpolation.
// ----------------------------------------------------------------------------
// Channel   Signals                    Direction  Handshake
// command   start_i, cmd_i, busy_o     in         start_i && !busy_o
// result    res_valid_o, res_o         out        strobe, one cycle
// config    cfg_we_i, cfg_wdata_i      in         cfg_we_i
//
// A write word goes through the write state back to idle. An evaluate word
// keeps the unit busy for up to six search probes, each a read and a compare,
// the close of the search, four fetches (segment ends, first and last point),
// two 48-step divisions (slope, then position) in the four-cell divider ring
// and the output state; the result strobe follows in the next cycle.
// Reset restores the table with valid bits, so no clearing pass is needed.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_unit
  import plti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  plti_in_t        cmd_i,
  output logic            busy_o,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  output logic            res_valid_o,
  output plti_out_t       res_o
);

  plti_state_e state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [MaxPoints-1:0] vld_q;
  plti_in_t in_q;
  logic [IdxW-1:0] lo_q, hi_q, seg_q, probe_q;
  logic phase_q;
  logic [5:0] step_q;
  logic last_step;
  logic signed [31:0] xj_q, xk_q, yj_q, yk_q, x0_q, xn_q;
  logic [1:0] fetch_q;
  logic [31:0] slope_q;
  logic [IdxW-1:0] n_m1;
  logic [CntW-1:0] n_eff;

  // RAM
  logic            we;
  logic [IdxW-1:0] raddr;
  logic [63:0]     rdata_raw;
  logic [63:0]     rdata;
  logic            rvld_q;
  logic [IdxW-1:0] raddr_q;

  assign n_eff = (count_q < CntW'(2)) ? CntW'(2) :
                 (count_q > CntW'(MaxPoints)) ? CntW'(MaxPoints) : count_q;
  assign n_m1  = IdxW'(n_eff - CntW'(1));

  assign we = (state_q == StWrite);

  assign last_step = (step_q == 6'(QuotW - 1));

  plti_ram #(.Width(64), .Depth(MaxPoints)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (in_q.point_index),
    .wdata_i ({in_q.x_value, in_q.y_value}),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  // Unwritten entries read as their reset values.
  always_comb begin
    if (rvld_q) rdata = rdata_raw;
    else if (raddr_q == IdxW'(1)) rdata = {32'sh0001_0000, 32'sh0};
    else rdata = '0;
  end

  logic [IdxW-1:0] mid;
  assign mid = lo_q + IdxW'((hi_q - lo_q + IdxW'(1)) >> 1);

  always_comb begin
    raddr = mid;
    if (state_q == StFetch) begin
      case (fetch_q)
        2'd0:    raddr = seg_q;
        2'd1:    raddr = seg_q + IdxW'(1);
        2'd2:    raddr = '0;
        default: raddr = n_m1;
      endcase
    end
  end

  logic signed [31:0] rx, ry;
  assign rx = rdata[63:32];
  assign ry = rdata[31:0];

  // Segment differences.
  logic signed [32:0] dx, dy, xoff;
  logic [31:0] adx, ady;
  assign dx   = 33'(xk_q) - 33'(xj_q);
  assign dy   = 33'(yk_q) - 33'(yj_q);
  assign xoff = 33'(in_q.x_value) - 33'(xj_q);
  assign adx  = dx[32] ? 32'(-dx) : 32'(dx);
  assign ady  = dy[32] ? 32'(-dy) : 32'(dy);

  // The position division starts with the offset as its remainder. The offset
  // is below dx whenever it is used, so 48 steps give offset * 2^48 / dx and
  // the top 32 quotient bits are t in Q0.32.
  logic div_load, div_en;
  logic [QuotW-1:0] div_num, div_quo;
  logic [DataW:0]   div_rem;
  assign div_num = (state_d == StDivS) ? {ady, 16'h0} : '0;
  assign div_rem = (state_d == StDivS) ? '0 : {1'b0, xoff[31:0]};

  plti_div_chain u_div (
    .clk_i  (clk_i),
    .load_i (div_load),
    .en_i   (div_en),
    .rem_i  (div_rem),
    .num_i  (div_num),
    .den_i  (adx),
    .quo_o  (div_quo)
  );

  logic [31:0] t_hi_q;

  always_comb begin
    state_d  = state_q;
    div_load = 1'b0;
    div_en   = 1'b0;
    case (state_q)
      StIdle:   if (start_i) state_d = (cmd_i.command == CmdEval) ? StSearch : StWrite;
      StWrite:  state_d = StIdle;
      StSearch: if (lo_q >= hi_q) state_d = StFetch;
      StFetch:  if (fetch_q == 2'd3 && phase_q) begin
                  state_d  = StDivS;
                  div_load = 1'b1;
                end
      StDivS: begin
        div_en = 1'b1;
        if (last_step) begin
          state_d  = StDivT;
          div_load = 1'b1;
        end
      end
      StDivT: begin
        div_en = 1'b1;
        if (last_step) state_d = StDone;
      end
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  // Rounded product of the segment rise and t, taken in the output cycle.
  logic [63:0] prod;
  logic [31:0] t_val;
  assign t_val = t_hi_q;
  assign prod  = 64'(ady) * 64'(t_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= CntW'(2);
      vld_q       <= '0;
      res_valid_o <= 1'b0;
      phase_q     <= 1'b0;
      fetch_q     <= '0;
      step_q      <= '0;
      rvld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_o <= (state_q == StDone);
      rvld_q      <= vld_q[raddr];
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (state_q == StWrite) vld_q[in_q.point_index] <= 1'b1;
      if (state_q == StIdle) begin
        phase_q <= 1'b0;
        fetch_q <= '0;
        step_q  <= '0;
      end
      if (state_q == StSearch && lo_q < hi_q) phase_q <= !phase_q;
      if (state_q == StFetch) begin
        phase_q <= !phase_q;
        if (phase_q) fetch_q <= fetch_q + 2'd1;
      end
      if (state_q == StDivS || state_q == StDivT) begin
        step_q <= last_step ? '0 : step_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr;
    if (state_q == StIdle && start_i) begin
      in_q <= cmd_i;
      lo_q <= '0;
      hi_q <= IdxW'(n_eff - CntW'(2));
    end
    if (state_q == StSearch && lo_q < hi_q && phase_q) begin
      if (in_q.x_value >= rx) lo_q <= probe_q;
      else hi_q <= probe_q - IdxW'(1);
    end
    if (state_q == StSearch) begin
      probe_q <= mid;
      seg_q   <= hi_q;
    end
    if (state_q == StFetch && phase_q) begin
      case (fetch_q)
        2'd0:    begin xj_q <= rx; yj_q <= ry; end
        2'd1:    begin xk_q <= rx; yk_q <= ry; end
        2'd2:    x0_q <= rx;
        default: xn_q <= rx;
      endcase
    end
    if (state_q == StDivS && last_step) begin
      if (adx == '0) begin
        slope_q <= dy[32] ? 32'h8000_0000 : (dy == '0 ? 32'h0 : 32'h7FFF_FFFF);
      end else if (div_quo > 48'h7FFF_FFFF) begin
        slope_q <= (dy[32] ^ dx[32]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        slope_q <= (dy[32] ^ dx[32]) ? 32'(-div_quo[31:0]) : div_quo[31:0];
      end
    end
    if (state_q == StDivT && last_step) t_hi_q <= div_quo[QuotW-1:16];
    if (state_q == StDone) begin
      res_o.segment     <= seg_q;
      res_o.inside_span <= !(in_q.x_value < x0_q || in_q.x_value > xn_q);
      res_o.slope       <= (in_q.x_value < x0_q || in_q.x_value > xn_q) ? 32'h0 : slope_q;
      if (in_q.x_value <= xj_q) res_o.value <= yj_q;
      else if (in_q.x_value >= xk_q) res_o.value <= yk_q;
      else if (dy[32]) res_o.value <= 32'(yj_q - 32'((prod + 64'h8000_0000) >> 32));
      else res_o.value <= 32'(yj_q + 32'((prod + 64'h8000_0000) >> 32));
    end
  end

endmodule

[hdl/plti_ram.sv]
// ----------------------------------------------------------------------------
// plti_ram
// Generic single-port write, single-port read RAM with a registered read.
// ----------------------------------------------------------------------------
module plti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/plti_div_cell.sv]
// ----------------------------------------------------------------------------
// plti_div_cell
// One restoring-division cell: produces one quotient bit per cycle while enabled.
// ----------------------------------------------------------------------------
module plti_div_cell
  import plti_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DataW-1:0] den_i,
  input  plti_div_t        prev_i,
  output plti_div_t        next_o
);

  logic [DataW+1:0] shifted;
  logic [DataW+1:0] diff;
  logic             take;
  plti_div_t        next_d;

  always_comb begin
    shifted = {prev_i.rem, prev_i.num[QuotW-1]};
    diff    = shifted - {2'b00, den_i};
    take    = !diff[DataW+1];
    next_d.rem = take ? diff[DataW:0] : shifted[DataW:0];
    next_d.num = {prev_i.num[QuotW-2:0], 1'b0};
    next_d.quo = {prev_i.quo[QuotW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      next_o <= next_d;
    end
  end

endmodule

[hdl/plti_div_chain.sv]
// ----------------------------------------------------------------------------
// plti_div_chain
// A ring of four divider cells; each pass around the ring yields four bits.
// ----------------------------------------------------------------------------
module plti_div_chain
  import plti_pkg::*;
(
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             en_i,
  input  logic [DataW:0]   rem_i,
  input  logic [QuotW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic [QuotW-1:0] quo_o
);

  plti_div_t link [DivCells];
  plti_div_t head;

  always_comb begin
    head = link[DivCells-1];
    if (load_i) begin
      head.rem = rem_i;
      head.num = num_i;
      head.quo = '0;
    end
  end

  for (genvar c = 0; c < DivCells; c++) begin : g_cell
    plti_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i || load_i),
      .den_i  (den_i),
      .prev_i ((c == 0) ? head : link[(c == 0) ? 0 : c-1]),
      .next_o (link[c])
    );
  end

  assign quo_o = link[DivCells-1].quo;

endmodule

[hdl/plti_checker.sv]
// ----------------------------------------------------------------------------
// plti_checker
// Port-level checks for the interpolation unit.
// ----------------------------------------------------------------------------
module plti_checker
  import plti_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input plti_in_t cmd_i,
  input logic     busy_o,
  input logic     res_valid_o
);

  // A result word is a single-cycle strobe.
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe held");

  // An accepted word of either kind makes the unit busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("busy not raised");

  // A write word gives no result.
  a_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i.command == CmdWrite) |=> ##1 !res_valid_o)
    else $error("result after write");

endmodule

bind piecewise_linear_table_interp_unit plti_checker u_plti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .cmd_i       (cmd_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o)
);

[tb/piecewise_linear_table_interp_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_unit_tb
// Drives breakpoint writes and evaluate words into the interpolation unit,
// predicts every result from a local copy of the table and checks it field
// by field as the result strobe comes out.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_unit_tb;
  import plti_pkg::*;

  logic            clk_i;
  logic            rst_ni;
  logic            start_i;
  plti_in_t        cmd_i;
  logic            busy_o;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;
  logic            res_valid_o;
  plti_out_t       res_o;

  piecewise_linear_table_interp_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Local copy of the table and the count register.
  logic signed [31:0] tbl_x [MaxPoints];
  logic signed [31:0] tbl_y [MaxPoints];
  logic [CntW-1:0]    active_count;

  plti_in_t  word_queue [$];
  plti_out_t interp_expected [$];
  int        fail_count;
  int        result_count;
  int        eval_count;
  int        write_count;
  int        accept_count;
  logic      driver_hold;

  function automatic logic signed [31:0] slope_between(longint dy, longint dx);
    longint q;
    longint ady;
    longint adx;
    logic   neg;
    if (dx == 0) begin
      if (dy > 0) return 32'sh7fffffff;
      if (dy < 0) return 32'sh80000000;
      return '0;
    end
    neg = (dy < 0) != (dx < 0);
    ady = (dy < 0) ? -dy : dy;
    adx = (dx < 0) ? -dx : dx;
    q   = (ady <<< 16) / adx;
    if (neg) begin
      if (q >= 64'sd2147483648) return 32'sh80000000;
      return 32'(-q);
    end
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    return 32'(q);
  endfunction

  // Updates the table for a write word, or returns the expected result.
  function automatic logic interp_predict(plti_in_t w, output plti_out_t r);
    int                 n;
    int                 lo;
    int                 hi;
    int                 mid;
    longint             x;
    longint             xj;
    longint             xk;
    longint             yj;
    longint             yk;
    longint             dy;
    longint             v;
    logic [63:0]        t;
    logic [63:0]        ady;
    logic [63:0]        d;
    logic [127:0]       prod;
    logic               in_span;
    r = '0;
    if (w.command == CmdWrite) begin
      tbl_x[w.point_index] = w.x_value;
      tbl_y[w.point_index] = w.y_value;
      return 1'b0;
    end
    n = active_count;
    if (n < 2) n = 2;
    if (n > MaxPoints) n = MaxPoints;
    x  = w.x_value;
    lo = 0;
    hi = n - 2;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (x >= longint'(tbl_x[mid])) lo = mid;
      else hi = mid - 1;
    end
    xj = tbl_x[hi];
    xk = tbl_x[hi + 1];
    yj = tbl_y[hi];
    yk = tbl_y[hi + 1];
    if (x <= xj) begin
      v = yj;
    end else if (x >= xk) begin
      v = yk;
    end else begin
      t    = (unsigned'(x - xj) << 32) / unsigned'(xk - xj);
      dy   = yk - yj;
      ady  = (dy < 0) ? 64'(-dy) : 64'(dy);
      prod = 128'(ady) * 128'(t) + 128'h80000000;
      d    = 64'(prod >> 32);
      v    = (dy < 0) ? yj - longint'(d) : yj + longint'(d);
    end
    in_span = !(x < longint'(tbl_x[0]) || x > longint'(tbl_x[n - 1]));
    r.value       = 32'(v);
    r.slope       = in_span ? slope_between(yk - yj, xk - xj) : '0;
    r.inside_span = in_span;
    r.segment     = hi[IdxW-1:0];
    return 1'b1;
  endfunction

  // Driver: one word at a time from the queue, with a random gap before each.
  int gap_left;
  int seen_count;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i    <= 1'b0;
      cmd_i      <= '0;
      gap_left   <= 0;
      seen_count <= 0;
    end else if (start_i && seen_count != accept_count) begin
      // The word was taken at the last rising edge; start the next gap.
      start_i    <= 1'b0;
      seen_count <= accept_count;
      gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    end else if (!start_i && !driver_hold && word_queue.size() > 0) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else begin
        cmd_i   <= word_queue[0];
        start_i <= 1'b1;
      end
    end
  end

  // Acceptance and prediction at the rising edge.
  always @(posedge clk_i) begin
    plti_out_t exp_r;
    if (rst_ni && start_i && !busy_o) begin
      void'(word_queue.pop_front());
      accept_count++;
      if (interp_predict(cmd_i, exp_r)) begin
        interp_expected.push_back(exp_r);
        eval_count++;
      end else begin
        write_count++;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    plti_out_t e;
    if (rst_ni && res_valid_o) begin
      result_count++;
      if (interp_expected.size() == 0) begin
        $error("result with nothing expected: %h", res_o);
        fail_count++;
      end else begin
        e = interp_expected.pop_front();
        if (res_o.value !== e.value) begin
          $error("value: expected %h, actual %h", e.value, res_o.value);
          fail_count++;
        end
        if (res_o.slope !== e.slope) begin
          $error("slope: expected %h, actual %h", e.slope, res_o.slope);
          fail_count++;
        end
        if (res_o.inside_span !== e.inside_span) begin
          $error("inside_span: expected %b, actual %b", e.inside_span,
                 res_o.inside_span);
          fail_count++;
        end
        if (res_o.segment !== e.segment) begin
          $error("segment: expected %0d, actual %0d", e.segment, res_o.segment);
          fail_count++;
        end
      end
    end
  end

  function automatic plti_in_t make_write(int idx, logic signed [31:0] x,
                                           logic signed [31:0] y);
    plti_in_t w;
    w.command     = CmdWrite;
    w.point_index = idx[IdxW-1:0];
    w.x_value     = x;
    w.y_value     = y;
    return w;
  endfunction

  function automatic plti_in_t make_eval(logic signed [31:0] x);
    plti_in_t w;
    w.command     = CmdEval;
    w.point_index = 6'($urandom);
    w.x_value     = x;
    w.y_value     = $urandom;
    return w;
  endfunction

  task automatic drain();
    while (word_queue.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (start_i || busy_o || interp_expected.size() != 0) @(posedge clk_i);
    // A trailing write word gives no strobe; let the block settle.
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_count(int n);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[CntW-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    active_count = n[CntW-1:0];
  endtask

  // Loads an ascending table of n points with random content.
  task automatic load_table(int n, int wide);
    longint xv;
    longint span;
    span = wide ? (64'sd4294967295 / n) : 64'($urandom_range(1, 1 << 20));
    xv   = wide ? -64'sd2147483648 : $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    for (int i = 0; i < n; i++) begin
      word_queue.push_back(make_write(i, 32'(xv), $urandom));
      xv = xv + 1 + longint'($urandom_range(0, 32'(span)));
      if (xv > 64'sd2147483647 - (n - i)) xv = 64'sd2147483647 - (n - i - 1);
    end
  endtask

  task automatic eval_burst(int cnt, int n);
    logic signed [31:0] xq;
    int                 p;
    for (int i = 0; i < cnt; i++) begin
      p = $urandom_range(0, n - 1);
      case ($urandom_range(0, 5))
        0: xq = $urandom;
        1: xq = tbl_x[p];
        2: xq = tbl_x[p] + $signed($urandom_range(0, 7)) - 3;
        default: xq = tbl_x[p] + ($urandom >> $urandom_range(1, 31));
      endcase
      word_queue.push_back(make_eval(xq));
    end
  endtask

  initial begin
    int sizes [6] = '{2, 64, 5, 17, 33, 3};
    int n;
    fail_count   = 0;
    result_count = 0;
    eval_count   = 0;
    write_count  = 0;
    accept_count = 0;
    driver_hold  = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    for (int i = 0; i < MaxPoints; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
    end
    tbl_x[1]     = 32'sh10000;
    active_count = 7'd2;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset table, extremes, degenerate segments.
    word_queue.push_back(make_eval(32'sh80000000));
    word_queue.push_back(make_eval(32'sh7fffffff));
    word_queue.push_back(make_eval(32'sh00008000));
    word_queue.push_back(make_eval(32'sh00000000));
    word_queue.push_back(make_eval(32'sh00010000));
    // Full span with extreme y, then a one-wide step with extreme y that saturates.
    word_queue.push_back(make_write(0, 32'sh80000000, 32'sh7fffffff));
    word_queue.push_back(make_write(1, 32'sh7fffffff, 32'sh80000000));
    word_queue.push_back(make_eval(32'sh00000000));
    word_queue.push_back(make_eval(32'sh7ffffffe));
    word_queue.push_back(make_write(0, 32'sh00000000, 32'sh80000000));
    word_queue.push_back(make_write(1, 32'sh00000001, 32'sh7fffffff));
    word_queue.push_back(make_eval(32'sh00000000));
    word_queue.push_back(make_eval(32'sh00000001));
    // Zero width segment, then a descending one.
    word_queue.push_back(make_write(1, 32'sh00000000, 32'sh00050000));
    word_queue.push_back(make_eval(32'sh00000000));
    word_queue.push_back(make_write(1, 32'sh00000000, 32'sh80000000));
    word_queue.push_back(make_eval(32'sh00000000));
    word_queue.push_back(make_write(1, 32'sh00000000, 32'sh80000000));
    word_queue.push_back(make_write(0, 32'sh00000000, 32'sh80000000));
    word_queue.push_back(make_eval(32'sh00000000));
    word_queue.push_back(make_write(0, 32'sh00030000, 32'sh00010000));
    word_queue.push_back(make_write(1, 32'shfffd0000, 32'sh00070000));
    word_queue.push_back(make_eval(32'sh00000000));
    word_queue.push_back(make_write(63, 32'sh7fffffff, 32'sh12345678));
    drain();

    // Count below the minimum and above the maximum.
    set_count(0);
    load_table(2, 1);
    eval_burst(6, 2);
    drain();
    set_count(127);
    load_table(64, 1);
    eval_burst(10, 64);
    drain();

    // The sender pauses after one word until every expected result has come.
    eval_burst(3, 64);
    while (word_queue.size() > 2) @(posedge clk_i);
    driver_hold = 1'b1;
    while (interp_expected.size() != 0 || busy_o) @(posedge clk_i);
    driver_hold = 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      n = sizes[ph];
      set_count(n);
      load_table(n, ph % 2);
      eval_burst(22, n);
      // A rewrite of a single breakpoint among the queries, once per table size.
      word_queue.push_back(make_write($urandom_range(0, 63), $urandom, $urandom));
      eval_burst(11, n);
      drain();
    end
    set_count(1);
    eval_burst(10, 2);
    drain();

    $display("Covered %0d evaluate and %0d write words, %0d results checked.",
             eval_count, write_count, result_count);
    $display("Table sizes from 2 to 64 points, out of range counts included.");
    if (fail_count == 0 && interp_expected.size() == 0) begin
      $display("PASS piecewise_linear_table_interp_unit");
    end else begin
      $display("FAIL piecewise_linear_table_interp_unit");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL piecewise_linear_table_interp_unit");
    $finish;
  end

endmodule
